// ===== design/dsct_pkg.sv =====
// ----------------------------------------------------------------------------
// dsct_pkg - shared types and codes of the darknet /24 color table
// Item and result structs, opcodes, status codes, register map and the
// control bundle handed from the merge unit to the sequencer.
// ----------------------------------------------------------------------------
package dsct_pkg;

  // opcodes
  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_REBUILD = 2'd2;
  localparam logic [1:0] OP_COMMIT  = 2'd3;

  // insert status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_DROP      = 3'd2;
  localparam logic [2:0] ST_EXCLUDE   = 3'd3;
  localparam logic [2:0] ST_BAD_COLOR = 3'd4;

  // configuration register map, word index taken from paddr[2]
  localparam int unsigned CFG_AW          = 3;
  localparam logic        REG_DARKNET_OCT = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic        is_ipv4;
    logic [5:0]  prefix_len;
    logic [7:0]  prefix_color;
    logic        exclude_default;
  } item_t;

  typedef struct packed {
    logic [7:0] color;
    logic [2:0] status;
    logic [9:0] new_count;
    logic [9:0] overlap_count;
  } result_t;

  typedef struct packed {
    logic       fail;
    logic [2:0] status;
    logic       inc_new;
    logic       inc_over;
  } merge_ctl_t;

endpackage

// ===== design/dsct_ram.sv =====
// ----------------------------------------------------------------------------
// dsct_ram - generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/dsct_cfg.sv =====
// ----------------------------------------------------------------------------
// dsct_cfg - apb register slice
// Holds the darknet octet; zero wait states.
// ----------------------------------------------------------------------------
module dsct_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [dsct_pkg::CFG_AW-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o,
  output logic [7:0]                  octet_o
);
  import dsct_pkg::*;

  logic [7:0] octet_q, octet_d;
  logic       wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_DARKNET_OCT);

  always_comb begin
    octet_d = octet_q;
    if (wr_en) begin
      octet_d = pwdata_i[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octet_q <= 8'd0;
    end else begin
      octet_q <= octet_d;
    end
  end

  assign prdata_o = (psel_i && (paddr_i[2] == REG_DARKNET_OCT)) ? {24'd0, octet_q} : 32'd0;
  assign octet_o  = octet_q;

endmodule

// ===== design/dsct_merge.sv =====
// ----------------------------------------------------------------------------
// dsct_merge - color merge unit
// Merges an insert color into one table entry and flags conflicts.
// ----------------------------------------------------------------------------
module dsct_merge #(
  parameter int COLOR_BITS = 8
) (
  input  logic [COLOR_BITS-1:0]  entry_i,
  input  logic [COLOR_BITS-1:0]  color_i,
  input  logic                   excl_i,
  output logic [COLOR_BITS-1:0]  wdata_o,
  output dsct_pkg::merge_ctl_t   ctl_o
);
  import dsct_pkg::*;

  logic e_zero, e_multi, c_zero;

  assign e_zero  = (entry_i == '0);
  assign e_multi = (entry_i > COLOR_BITS'(1));
  assign c_zero  = (color_i == '0);

  always_comb begin
    ctl_o   = '0;
    wdata_o = entry_i | color_i;
    if ((e_zero && !c_zero) || (e_multi && c_zero)) begin
      ctl_o.fail   = 1'b1;
      ctl_o.status = ST_DROP;
    end else if (entry_i[0]) begin
      // entry still shares the default sink
      if (excl_i) begin
        if (e_multi) begin
          ctl_o.fail   = 1'b1;
          ctl_o.status = ST_EXCLUDE;
        end else begin
          wdata_o       = color_i;
          ctl_o.inc_new = 1'b1;
        end
      end else begin
        ctl_o.inc_new = 1'b1;
      end
    end else if (e_multi) begin
      ctl_o.inc_over = 1'b1;
    end else begin
      ctl_o.inc_new = 1'b1;
    end
  end

endmodule

// ===== design/darknet_slash24_color_table.sv =====
// ----------------------------------------------------------------------------
// darknet_slash24_color_table - two-bank sink color table for a /8 darknet
// Lookup, prefix insert, shadow rebuild and bank commit under one sequencer.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken when start is high and busy is low,
// and its single result shows on result_o for one cycle with done_o high; the
// receiver must take it then. A commit answers in the cycle after it is
// taken. A lookup answers from the lookup state; an insert of a valid
// prefix passes through setup and then does one ram read-modify-write per
// cycle for each /24 entry the prefix spans; a rejected insert answers from
// setup; a rebuild walks every shadow entry through the single ram write
// port. After reset both banks are filled with 1 while busy stays high;
// register writes are taken as usual. TABLE_ENTRIES must be a power of two.
module darknet_slash24_color_table #(
  parameter int TABLE_ENTRIES = 65536,
  parameter int MIN_PREFIX    = 15,
  parameter int COLOR_BITS    = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsct_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  dsct_pkg::item_t             item_i,
  output logic                        done_o,
  output dsct_pkg::result_t           result_o
);
  import dsct_pkg::*;

  localparam int              IDX_W   = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IdxLast = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_LOOKUP    = 3'd2;
  localparam logic [2:0] S_INS_SETUP = 3'd3;
  localparam logic [2:0] S_INS_RUN   = 3'd4;
  localparam logic [2:0] S_FILL      = 3'd5;

  logic [2:0]       state_q, state_d;
  item_t            item_q, item_d;
  logic             active_q, active_d;
  logic             failed_q, failed_d;
  logic [IDX_W-1:0] fill_idx_q, fill_idx_d;
  logic [1:0]       fill_bank_q, fill_bank_d;
  logic [23:0]      cur_q, cur_d;
  logic [23:0]      end_q, end_d;
  logic [9:0]       new_q, new_d;
  logic [9:0]       over_q, over_d;
  logic             done_q, done_d;
  result_t          res_q, res_d;

  logic [7:0]            octet;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [COLOR_BITS-1:0] wr_data, rdata0, rdata1;
  logic [1:0]            we;
  logic [COLOR_BITS-1:0] shadow_rdata, active_rdata;
  logic [COLOR_BITS-1:0] ins_color, merge_wdata;
  merge_ctl_t            merge_ctl;
  logic [5:0]            len_c;
  logic [4:0]            host;
  logic [23:0]           mask, first_s, last_s, cur_inc;
  logic [9:0]            new_sum, over_sum;
  logic                  hit;

  dsct_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .octet_o   (octet)
  );

  dsct_ram #(.WIDTH(COLOR_BITS), .DEPTH(TABLE_ENTRIES)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we[0]),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  dsct_ram #(.WIDTH(COLOR_BITS), .DEPTH(TABLE_ENTRIES)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we[1]),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  assign shadow_rdata = active_q ? rdata0 : rdata1;
  assign active_rdata = active_q ? rdata1 : rdata0;
  assign ins_color    = COLOR_BITS'(item_q.prefix_color);

  dsct_merge #(.COLOR_BITS(COLOR_BITS)) u_merge (
    .entry_i (shadow_rdata),
    .color_i (ins_color),
    .excl_i  (item_q.exclude_default),
    .wdata_o (merge_wdata),
    .ctl_o   (merge_ctl)
  );

  // /24 range covered by the prefix
  always_comb begin
    len_c    = (item_q.prefix_len > 6'd32) ? 6'd32 : item_q.prefix_len;
    host     = (len_c >= 6'd24) ? 5'd0 : 5'(6'd24 - len_c);
    mask     = 24'hFFFFFF << host;
    first_s  = item_q.address[31:8] & mask;
    last_s   = first_s | ~mask;
    cur_inc  = cur_q + 24'd1;
    new_sum  = new_q + 10'(merge_ctl.inc_new);
    over_sum = over_q + 10'(merge_ctl.inc_over);
    hit      = item_q.is_ipv4 && (item_q.address[31:24] == octet);
  end

  always_comb begin
    case (state_q)
      S_INS_SETUP: rd_addr = first_s[IDX_W-1:0];
      S_INS_RUN:   rd_addr = cur_inc[IDX_W-1:0];
      default:     rd_addr = item_i.address[8 +: IDX_W];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    active_d    = active_q;
    failed_d    = failed_q;
    fill_idx_d  = fill_idx_q;
    fill_bank_d = fill_bank_q;
    cur_d       = cur_q;
    end_d       = end_q;
    new_d       = new_q;
    over_d      = over_q;
    done_d      = 1'b0;
    res_d       = res_q;
    we          = 2'b00;
    wr_addr     = fill_idx_q;
    wr_data     = COLOR_BITS'(1);
    unique case (state_q) inside
      S_CLEAR, S_FILL: begin
        we         = fill_bank_q;
        fill_idx_d = fill_idx_q + IDX_W'(1);
        if (fill_idx_q == IdxLast) begin
          state_d = S_IDLE;
          if (state_q == S_FILL) begin
            failed_d = 1'b0;
            done_d   = 1'b1;
            res_d    = '0;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          item_d = item_i;
          unique case (item_i.opcode)
            OP_LOOKUP: state_d = S_LOOKUP;
            OP_INSERT: state_d = S_INS_SETUP;
            OP_REBUILD: begin
              state_d     = S_FILL;
              fill_idx_d  = '0;
              fill_bank_d = active_q ? 2'b01 : 2'b10;
            end
            default: begin
              // commit is refused while a failure is pending
              if (!failed_q) begin
                active_d = ~active_q;
              end
              done_d = 1'b1;
              res_d  = '0;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        res_d = '0;
        if (hit) begin
          res_d.color = 8'(active_rdata);
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_INS_SETUP: begin
        res_d  = '0;
        new_d  = '0;
        over_d = '0;
        if (ins_color == COLOR_BITS'(1)) begin
          res_d.status = ST_BAD_COLOR;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (len_c < 6'(MIN_PREFIX)) begin
          res_d.status = ST_SHORT;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cur_d   = first_s;
          end_d   = last_s;
          state_d = S_INS_RUN;
        end
      end
      S_INS_RUN: begin
        res_d = '0;
        if (merge_ctl.fail) begin
          failed_d            = 1'b1;
          res_d.status        = merge_ctl.status;
          res_d.new_count     = new_q;
          res_d.overlap_count = over_q;
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end else begin
          // write this entry while the next one is being read
          we      = active_q ? 2'b01 : 2'b10;
          wr_addr = cur_q[IDX_W-1:0];
          wr_data = merge_wdata;
          new_d   = new_sum;
          over_d  = over_sum;
          if (cur_q == end_q) begin
            res_d.status        = ST_OK;
            res_d.new_count     = new_sum;
            res_d.overlap_count = over_sum;
            done_d              = 1'b1;
            state_d             = S_IDLE;
          end else begin
            cur_d = cur_inc;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      active_q    <= 1'b0;
      failed_q    <= 1'b0;
      fill_idx_q  <= '0;
      fill_bank_q <= 2'b11;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      failed_q    <= failed_d;
      fill_idx_q  <= fill_idx_d;
      fill_bank_q <= fill_bank_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cur_q  <= cur_d;
    end_q  <= end_d;
    new_q  <= new_d;
    over_q <= over_d;
    res_q  <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // inserts never touch the bank that lookups read
  a_ins_shadow_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_RUN) |-> !(active_q ? we[1] : we[0]))
    else $error("insert wrote the active bank");

  // a pending failure blocks the bank swap
  a_commit_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start && item_i.opcode == OP_COMMIT && failed_q)
      |=> $stable(active_q))
    else $error("commit swapped banks despite failure");

  // a conflict result always leaves the failure flag set
  a_conflict_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == ST_DROP || res_q.status == ST_EXCLUDE)) |-> failed_q)
    else $error("conflict reported without failure flag");

  // the walk never passes the end of the prefix range
  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_RUN) |-> (cur_q <= end_q))
    else $error("insert walk overran its range");

endmodule
